/* rtl/core/generational_slot_allocator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot allocator checkers.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define GSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/gsa_pkg.sv */
// ----------------------------------------------------------------------------
// gsa_pkg
// Types and constants of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

   localparam int SLOT_COUNT_DEF = 1024;
   localparam int GEN_W          = 32;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_CHECK   = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_LIVE = 2'd2,
      STATUS_STALE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_FETCH,
      STATE_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic clear_last;
      logic finish_early;
   } ctrl_in_type;

   typedef struct packed {
      logic clearing;
      logic idle;
      logic fetch;
      logic finish;
   } ctrl_out_type;

endpackage

/* rtl/core/gsa_ram.sv */
// ----------------------------------------------------------------------------
// gsa_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/gsa_ctrl.sv */
// ----------------------------------------------------------------------------
// gsa_ctrl
// Sequencer: clearing pass, idle, fetch and finish phases of a transaction.
// ----------------------------------------------------------------------------
module gsa_ctrl
   import gsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_in_type  cin,
   output ctrl_out_type cout
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_CLEAR: begin
            if (cin.clear_last) state_in = STATE_IDLE;
         end
         STATE_IDLE: begin
            if (cin.start) state_in = STATE_FETCH;
         end
         STATE_FETCH: begin
            state_in = cin.finish_early ? STATE_IDLE : STATE_FINISH;
         end
         STATE_FINISH: begin
            state_in = STATE_IDLE;
         end
         default: begin
            state_in = STATE_CLEAR;
         end
      endcase
   end

   always_comb begin
      cout = '0;
      unique case (state_ff)
         STATE_CLEAR:  cout.clearing = 1'b1;
         STATE_IDLE:   cout.idle     = 1'b1;
         STATE_FETCH:  cout.fetch    = 1'b1;
         STATE_FINISH: cout.finish   = 1'b1;
         default:      cout.clearing = 1'b1;
      endcase
   end

endmodule

/* rtl/core/generational_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// generational_slot_allocator_unit
// Slot allocator handing out handles of slot index and 32-bit generation.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass (busy high) that zeroes all
// generations and live marks and loads the free stack. A transaction is
// taken when start is high and busy is low; its result shows on the rsp_
// ports for one cycle with rsp_valid, and must be taken then. Check, and
// any operation that fails early (table full, slot not live, out of range),
// registers its result in the fetch state; allocate, a successful release
// and read register theirs in the finish state, because each needs two
// registered memory reads in turn (free stack then generation, position
// then live list, live list then generation). busy falls in the cycle the
// result shows, so the next transaction can be taken in that same cycle.
// ----------------------------------------------------------------------------
module generational_slot_allocator_unit
   import gsa_pkg::*;
#(
   parameter  int SLOT_COUNT = SLOT_COUNT_DEF,
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_mode,
   input  logic [IDX_W-1:0] req_slot_index,
   input  logic [GEN_W-1:0] req_handle_generation,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [IDX_W-1:0] rsp_out_index,
   output logic [GEN_W-1:0] rsp_out_generation,
   output logic [CNT_W-1:0] rsp_live_count
);

   localparam int SG_W = GEN_W + 1;

   ctrl_in_type  cin;
   ctrl_out_type cout;

   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] live_total_ff, live_total_in;
   mode_type         mode_ff, mode_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [GEN_W-1:0] hgen_ff, hgen_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [GEN_W-1:0] gen_ff, gen_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [GEN_W-1:0] rsp_gen_ff, rsp_gen_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic             sg_we;
   logic [IDX_W-1:0] sg_wa, sg_ra;
   logic [SG_W-1:0]  sg_wd, sg_rd;
   logic             fs_we;
   logic [IDX_W-1:0] fs_wa, fs_wd, fs_ra, fs_rd;
   logic             ll_we;
   logic [IDX_W-1:0] ll_wa, ll_wd, ll_ra, ll_rd;
   logic             lp_we;
   logic [IDX_W-1:0] lp_wa, lp_wd, lp_rd;

   logic             accept;
   logic             rd_live;
   logic [GEN_W-1:0] rd_gen;
   logic             idx_oob;
   logic [GEN_W-1:0] next_gen;

   // live mark in the top bit, generation below
   gsa_ram #(.WIDTH(SG_W), .DEPTH(SLOT_COUNT)) u_slot_mem (
      .clock(clock), .wr_en(sg_we), .wr_addr(sg_wa), .wr_data(sg_wd),
      .rd_addr(sg_ra), .rd_data(sg_rd)
   );

   gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free_mem (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_ra), .rd_data(fs_rd)
   );

   gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_list_mem (
      .clock(clock), .wr_en(ll_we), .wr_addr(ll_wa), .wr_data(ll_wd),
      .rd_addr(ll_ra), .rd_data(ll_rd)
   );

   gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_pos_mem (
      .clock(clock), .wr_en(lp_we), .wr_addr(lp_wa), .wr_data(lp_wd),
      .rd_addr(req_slot_index), .rd_data(lp_rd)
   );

   gsa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .cin(cin), .cout(cout)
   );

   assign accept   = start && cout.idle;
   assign rd_live  = sg_rd[SG_W-1];
   assign rd_gen   = sg_rd[GEN_W-1:0];
   assign idx_oob  = CNT_W'(idx_ff) >= CNT_W'(SLOT_COUNT);
   assign next_gen = rd_gen + GEN_W'(1);

   always_comb begin
      clr_in        = clr_ff;
      free_count_in = free_count_ff;
      live_total_in = live_total_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      hgen_in       = hgen_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      gen_in        = gen_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_count_in  = rsp_count_ff;
      cin.start        = start;
      cin.clear_last   = clr_ff == IDX_W'(SLOT_COUNT - 1);
      cin.finish_early = 1'b0;

      sg_we = 1'b0;
      sg_wa = idx_ff;
      sg_wd = '0;
      sg_ra = req_slot_index;
      fs_we = 1'b0;
      fs_wa = free_count_ff[IDX_W-1:0];
      fs_wd = idx_ff;
      fs_ra = free_count_ff[IDX_W-1:0] - IDX_W'(1);
      ll_we = 1'b0;
      ll_wa = live_total_ff[IDX_W-1:0];
      ll_wd = slot_ff;
      ll_ra = req_slot_index;
      lp_we = 1'b0;
      lp_wa = slot_ff;
      lp_wd = live_total_ff[IDX_W-1:0];

      if (cout.clearing) begin
         sg_we  = 1'b1;
         sg_wa  = clr_ff;
         sg_wd  = '0;
         fs_we  = 1'b1;
         fs_wa  = clr_ff;
         fs_wd  = IDX_W'(SLOT_COUNT - 1) - clr_ff;
         clr_in = clr_ff + IDX_W'(1);
      end

      if (accept) begin
         mode_in = mode_type'(req_mode);
         idx_in  = req_slot_index;
         hgen_in = req_handle_generation;
      end

      if (cout.fetch) begin
         rsp_count_in = live_total_ff;
         unique case (mode_ff)
            MODE_ALLOC: begin
               sg_ra = fs_rd;
               if (free_count_ff == '0) begin
                  cin.finish_early = 1'b1;
                  rsp_status_in    = STATUS_FULL;
                  rsp_index_in     = '0;
                  rsp_gen_in       = '0;
               end else begin
                  slot_in       = fs_rd;
                  free_count_in = free_count_ff - CNT_W'(1);
               end
            end
            MODE_RELEASE: begin
               ll_ra        = live_total_ff[IDX_W-1:0] - IDX_W'(1);
               rsp_index_in = idx_ff;
               if (idx_oob) begin
                  cin.finish_early = 1'b1;
                  rsp_status_in    = STATUS_STALE;
                  rsp_gen_in       = '0;
               end else if (!rd_live) begin
                  cin.finish_early = 1'b1;
                  rsp_status_in    = STATUS_NOT_LIVE;
                  rsp_gen_in       = rd_gen;
               end else begin
                  sg_we         = 1'b1;
                  sg_wa         = idx_ff;
                  sg_wd         = {1'b0, rd_gen};
                  fs_we         = 1'b1;
                  free_count_in = free_count_ff + CNT_W'(1);
                  live_total_in = live_total_ff - CNT_W'(1);
                  pos_in        = lp_rd;
                  gen_in        = rd_gen;
               end
            end
            MODE_CHECK: begin
               cin.finish_early = 1'b1;
               rsp_index_in     = idx_ff;
               rsp_gen_in       = rd_gen;
               if (idx_oob) begin
                  rsp_status_in = STATUS_STALE;
                  rsp_gen_in    = '0;
               end else if (hgen_ff != rd_gen) begin
                  rsp_status_in = STATUS_STALE;
               end else if (!rd_live) begin
                  rsp_status_in = STATUS_NOT_LIVE;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
            end
            MODE_READ: begin
               sg_ra = ll_rd;
               if (CNT_W'(idx_ff) >= live_total_ff) begin
                  cin.finish_early = 1'b1;
                  rsp_status_in    = STATUS_STALE;
                  rsp_index_in     = '0;
                  rsp_gen_in       = '0;
               end else begin
                  slot_in = ll_rd;
               end
            end
            default: begin
               cin.finish_early = 1'b1;
            end
         endcase
         rsp_valid_in = cin.finish_early;
      end

      if (cout.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         unique case (mode_ff)
            MODE_ALLOC: begin
               sg_we         = 1'b1;
               sg_wa         = slot_ff;
               sg_wd         = {1'b1, next_gen};
               ll_we         = 1'b1;
               lp_we         = 1'b1;
               live_total_in = live_total_ff + CNT_W'(1);
               rsp_index_in  = slot_ff;
               rsp_gen_in    = next_gen;
               rsp_count_in  = live_total_ff + CNT_W'(1);
            end
            MODE_RELEASE: begin
               // move the last live entry into the freed position
               ll_we        = 1'b1;
               ll_wa        = pos_ff;
               ll_wd        = ll_rd;
               lp_we        = 1'b1;
               lp_wa        = ll_rd;
               lp_wd        = pos_ff;
               rsp_index_in = idx_ff;
               rsp_gen_in   = gen_ff;
               rsp_count_in = live_total_ff;
            end
            MODE_READ: begin
               rsp_index_in = slot_ff;
               rsp_gen_in   = rd_gen;
               rsp_count_in = live_total_ff;
            end
            default: begin
               rsp_count_in = live_total_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         free_count_ff <= CNT_W'(SLOT_COUNT);
         live_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         live_total_ff <= live_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      hgen_ff       <= hgen_in;
      slot_ff       <= slot_in;
      pos_ff        <= pos_in;
      gen_ff        <= gen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy               = !cout.idle;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_index      = rsp_index_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_live_count     = rsp_count_ff;

endmodule

/* rtl/core/gsa_checker.sv */
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "generational_slot_allocator_unit_assert.svh"

module gsa_checker
   import gsa_pkg::*;
#(
   parameter  int SLOT_COUNT = SLOT_COUNT_DEF,
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic [1:0]       rsp_status,
   input logic [IDX_W-1:0] rsp_out_index,
   input logic [GEN_W-1:0] rsp_out_generation,
   input logic [CNT_W-1:0] rsp_live_count
);

   `GSA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `GSA_ASSERT_IMP(a_rsp_ends_busy, clock, reset, rsp_valid, !busy && $past(busy), "result outside a transaction")
   `GSA_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `GSA_ASSERT_IMP(a_full_result, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_live_count == CNT_W'(SLOT_COUNT) && rsp_out_index == '0 && rsp_out_generation == '0, "full status while not full")

endmodule

bind generational_slot_allocator_unit gsa_checker #(.SLOT_COUNT(SLOT_COUNT)) u_gsa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_out_index(rsp_out_index),
   .rsp_out_generation(rsp_out_generation), .rsp_live_count(rsp_live_count)
);
